>>> rtl/core/rfb_pkg.sv
// ----------------------------------------------------------------------------
// rfb_pkg
// Shared types, codes and constants of the rotated framebuffer draw engine.
// ----------------------------------------------------------------------------
package rfb_pkg;

   localparam int PLANE_BYTES_DEF = 4736;
   localparam int COORD_BITS      = 9;
   localparam int ADDR_BITS       = 13;
   // mapped coordinates: 10-bit panel size minus 9-bit coordinate plus pad, with sign
   localparam int MAP_BITS        = 12;
   // row * stride + column byte
   localparam int POS_BITS        = 19;
   localparam int QUEUE_DEPTH     = 2;

   localparam int CSR_INDEX_BITS  = 3;
   localparam int CSR_DATA_BITS   = 10;

   // command codes
   localparam logic [2:0] FUNC_PIXEL = 3'd0;
   localparam logic [2:0] FUNC_HLINE = 3'd1;
   localparam logic [2:0] FUNC_VLINE = 3'd2;
   localparam logic [2:0] FUNC_RECT  = 3'd3;
   localparam logic [2:0] FUNC_BOX   = 3'd4;
   localparam logic [2:0] FUNC_READ  = 3'd5;

   // colors
   localparam logic [1:0] COLOR_BLACK = 2'd0;
   localparam logic [1:0] COLOR_WHITE = 2'd1;
   localparam logic [1:0] COLOR_RED   = 2'd2;

   // rotation modes
   localparam logic [1:0] ROT_0   = 2'd0;
   localparam logic [1:0] ROT_90  = 2'd1;
   localparam logic [1:0] ROT_180 = 2'd2;
   localparam logic [1:0] ROT_270 = 2'd3;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROTATION      = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MIRROR_ENABLE = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PAD_OFFSET    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RED_ENABLE    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PANEL_WIDTH   = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PANEL_HEIGHT  = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LINE_STRIDE   = 3'd6;

   localparam logic [9:0] PANEL_WIDTH_RST  = 10'd296;
   localparam logic [9:0] PANEL_HEIGHT_RST = 10'd128;
   localparam logic [6:0] LINE_STRIDE_RST  = 7'd16;

   localparam logic [7:0] BW_BLANK  = 8'hFF;
   localparam logic [7:0] RED_BLANK = 8'h00;
   localparam logic [7:0] MASK_MSB  = 8'h80;

   typedef enum logic [1:0] {
      KIND_NOP,
      KIND_FILL,
      KIND_OUTLINE,
      KIND_READ
   } kind_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SPAN,
      ST_MAP,
      ST_ADDR,
      ST_READ,
      ST_WRITE,
      ST_RDBYTE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [2:0]            func;
      logic [COORD_BITS-1:0] x1;
      logic [COORD_BITS-1:0] y1;
      logic [COORD_BITS-1:0] x2;
      logic [COORD_BITS-1:0] y2;
      logic [1:0]            color;
      logic [ADDR_BITS-1:0]  byte_address;
   } req_type;

   typedef struct packed {
      logic [7:0] bw_byte;
      logic [7:0] red_byte;
      logic       dropped;
   } rsp_type;

   typedef struct packed {
      logic [1:0] rotation;
      logic       mirror_enable;
      logic [2:0] pad_offset;
      logic       red_enable;
      logic [9:0] panel_width;
      logic [9:0] panel_height;
      logic [6:0] line_stride;
   } cfg_type;

   // classified command: a rectangle of pixels (filled or outline), a read or a no-op
   typedef struct packed {
      kind_type              kind;
      logic [COORD_BITS-1:0] xs;
      logic [COORD_BITS-1:0] xe;
      logic [COORD_BITS-1:0] ys;
      logic [COORD_BITS-1:0] ye;
      logic [1:0]            color;
      logic [ADDR_BITS-1:0]  addr;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } queue_head_type;

endpackage

>>> rtl/core/rotated_framebuffer_draw_engine.sv
// ----------------------------------------------------------------------------
// rotated_framebuffer_draw_engine
// Pixel, line, rectangle and box drawing into two 1-bit framebuffer planes,
// with rotation, mirror padding and byte read-back.
// ----------------------------------------------------------------------------
// Steps: byte read: read-byte, done. Draw: span setup, then per pixel
//   map, address, read, write if stored, or only map, address if dropped.
// Throughput: one command at a time in the sequencer, set by the single
//   read-modify-write port of the planes; a 2-beat queue takes commands ahead.
// Reset: synchronous; afterwards a clearing pass over all PLANE_BYTES bytes
//   sets the planes to white / no red, during which req_stall is held high.
module rotated_framebuffer_draw_engine #(
   parameter int PLANE_BYTES = rfb_pkg::PLANE_BYTES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  rfb_pkg::req_type                     req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output rfb_pkg::rsp_type                     rsp_payload,
   input  logic                                 csr_write_en,
   input  logic [rfb_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [rfb_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   rfb_pkg::cfg_type        cfg_ff, cfg_in;
   rfb_pkg::queue_head_type q_head;
   logic                    q_pop;
   logic                    clearing;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            rfb_pkg::CSR_ROTATION:      cfg_in.rotation      = csr_wdata[1:0];
            rfb_pkg::CSR_MIRROR_ENABLE: cfg_in.mirror_enable = csr_wdata[0];
            rfb_pkg::CSR_PAD_OFFSET:    cfg_in.pad_offset    = csr_wdata[2:0];
            rfb_pkg::CSR_RED_ENABLE:    cfg_in.red_enable    = csr_wdata[0];
            rfb_pkg::CSR_PANEL_WIDTH:   cfg_in.panel_width   = csr_wdata[9:0];
            rfb_pkg::CSR_PANEL_HEIGHT:  cfg_in.panel_height  = csr_wdata[9:0];
            rfb_pkg::CSR_LINE_STRIDE:   cfg_in.line_stride   = csr_wdata[6:0];
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rotation      <= rfb_pkg::ROT_0;
         cfg_ff.mirror_enable <= 1'b0;
         cfg_ff.pad_offset    <= '0;
         cfg_ff.red_enable    <= 1'b0;
         cfg_ff.panel_width   <= rfb_pkg::PANEL_WIDTH_RST;
         cfg_ff.panel_height  <= rfb_pkg::PANEL_HEIGHT_RST;
         cfg_ff.line_stride   <= rfb_pkg::LINE_STRIDE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rfb_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .clearing    (clearing),
      .q_pop       (q_pop),
      .q_head      (q_head)
   );

   rfb_back #(
      .PLANE_BYTES (PLANE_BYTES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .clearing    (clearing),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

>>> rtl/core/rfb_front.sv
// ----------------------------------------------------------------------------
// rfb_front
// Accepts command beats, sorts endpoints into span bounds and queues them.
// ----------------------------------------------------------------------------
module rfb_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  rfb_pkg::req_type       req_payload,
   input  logic                   clearing,
   input  logic                   q_pop,
   output rfb_pkg::queue_head_type q_head
);

   localparam int QW = (rfb_pkg::QUEUE_DEPTH > 1) ? $clog2(rfb_pkg::QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(rfb_pkg::QUEUE_DEPTH + 1);
   localparam logic [QW-1:0] LAST_SLOT = QW'(rfb_pkg::QUEUE_DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(rfb_pkg::QUEUE_DEPTH);

   rfb_pkg::entry_type entries_ff [rfb_pkg::QUEUE_DEPTH];
   rfb_pkg::entry_type entry_in;

   logic [QW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   logic push;
   logic [rfb_pkg::COORD_BITS-1:0] xlo, xhi, ylo, yhi;

   // classification
   always_comb begin
      xlo = (req_payload.x1 < req_payload.x2) ? req_payload.x1 : req_payload.x2;
      xhi = (req_payload.x1 < req_payload.x2) ? req_payload.x2 : req_payload.x1;
      ylo = (req_payload.y1 < req_payload.y2) ? req_payload.y1 : req_payload.y2;
      yhi = (req_payload.y1 < req_payload.y2) ? req_payload.y2 : req_payload.y1;

      entry_in.kind  = rfb_pkg::KIND_NOP;
      entry_in.xs    = req_payload.x1;
      entry_in.xe    = req_payload.x1;
      entry_in.ys    = req_payload.y1;
      entry_in.ye    = req_payload.y1;
      entry_in.color = req_payload.color;
      entry_in.addr  = req_payload.byte_address;

      case (req_payload.func)
         rfb_pkg::FUNC_PIXEL: begin
            entry_in.kind = rfb_pkg::KIND_FILL;
         end
         rfb_pkg::FUNC_HLINE: begin
            entry_in.kind = rfb_pkg::KIND_FILL;
            entry_in.xs   = xlo;
            entry_in.xe   = xhi;
         end
         rfb_pkg::FUNC_VLINE: begin
            entry_in.kind = rfb_pkg::KIND_FILL;
            entry_in.ys   = ylo;
            entry_in.ye   = yhi;
         end
         rfb_pkg::FUNC_RECT: begin
            entry_in.kind = rfb_pkg::KIND_OUTLINE;
            entry_in.xs   = xlo;
            entry_in.xe   = xhi;
            entry_in.ys   = ylo;
            entry_in.ye   = yhi;
         end
         rfb_pkg::FUNC_BOX: begin
            // rows run y1..y2 unsorted; an inverted box draws nothing
            entry_in.kind = (req_payload.y1 <= req_payload.y2) ? rfb_pkg::KIND_FILL
                                                               : rfb_pkg::KIND_NOP;
            entry_in.xs   = xlo;
            entry_in.xe   = xhi;
            entry_in.ye   = req_payload.y2;
         end
         rfb_pkg::FUNC_READ: begin
            entry_in.kind = rfb_pkg::KIND_READ;
         end
         default: begin
            entry_in.kind = rfb_pkg::KIND_NOP;
         end
      endcase
   end

   // queue control
   always_comb begin
      req_stall = clearing || (count_ff == FULL_COUNT);
      push      = req_valid && !req_stall;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;

      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + QW'(1);
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + QW'(1);
      end
      if (push && !q_pop) begin
         count_in = count_ff + CW'(1);
      end else if (q_pop && !push) begin
         count_in = count_ff - CW'(1);
      end

      q_head.valid = (count_ff != '0);
      q_head.entry = entries_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

>>> rtl/core/rfb_back.sv
// ----------------------------------------------------------------------------
// rfb_back
// Pixel sequencer: walks spans, rotates and maps each pixel, and does a
// read-modify-write of both framebuffer planes. Also serves byte reads.
// ----------------------------------------------------------------------------
module rfb_back #(
   parameter int PLANE_BYTES = rfb_pkg::PLANE_BYTES_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  rfb_pkg::cfg_type        cfg,
   input  rfb_pkg::queue_head_type q_head,
   output logic                    q_pop,
   output logic                    clearing,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output rfb_pkg::rsp_type        rsp_payload
);

   localparam int AW = (PLANE_BYTES > 1) ? $clog2(PLANE_BYTES) : 1;
   localparam logic [31:0]   PLANE_LIMIT = 32'(PLANE_BYTES);
   localparam logic [AW-1:0] LAST_ADDR   = AW'(PLANE_BYTES - 1);
   localparam int CB = rfb_pkg::COORD_BITS;
   localparam int MB = rfb_pkg::MAP_BITS;
   localparam int PB = rfb_pkg::POS_BITS;

   logic [7:0] bw_mem  [PLANE_BYTES];
   logic [7:0] red_mem [PLANE_BYTES];
   logic [7:0] bw_rd_ff, red_rd_ff;

   rfb_pkg::state_type state_ff, state_in;
   rfb_pkg::entry_type entry_ff, entry_in;
   rfb_pkg::rsp_type   rsp_ff, rsp_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic [1:0]    span_ff, span_in;
   logic [CB-1:0] xs_ff, xs_in, xe_ff, xe_in, ye_ff, ye_in;
   logic [CB-1:0] x_ff, x_in, y_ff, y_in;
   logic [MB-1:0] nx_ff, nx_in, ny_ff, ny_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [7:0]    mask_ff, mask_in;
   logic          drop_ff, drop_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // memory port controls
   logic          mem_we, rd_en;
   logic [AW-1:0] mem_waddr, rd_addr;
   logic [7:0]    bw_wdata, red_wdata;

   // span selection
   logic [CB-1:0] span_xs, span_xe, span_ys, span_ye;
   // advance to next pixel
   rfb_pkg::state_type adv_state;
   logic [CB-1:0] adv_x, adv_y;
   logic [1:0]    adv_span;
   // mapping
   logic [MB-1:0] xw, yw, pw_m1, ph_m1, map_nx, map_ny;
   // address
   logic [PB-1:0] pos_calc;
   logic          addr_ok, read_ok;
   logic [7:0]    bw_new, red_new;

   // outline: top row, bottom row, left column, right column
   always_comb begin
      span_xs = entry_ff.xs;
      span_xe = entry_ff.xe;
      span_ys = entry_ff.ys;
      span_ye = entry_ff.ye;
      if (entry_ff.kind == rfb_pkg::KIND_OUTLINE) begin
         case (span_ff)
            2'd0: span_ye = entry_ff.ys;
            2'd1: span_ys = entry_ff.ye;
            2'd2: span_xe = entry_ff.xs;
            default: span_xs = entry_ff.xe;
         endcase
      end
   end

   always_comb begin
      adv_x     = x_ff;
      adv_y     = y_ff;
      adv_span  = span_ff;
      if (x_ff != xe_ff) begin
         adv_x     = x_ff + CB'(1);
         adv_state = rfb_pkg::ST_MAP;
      end else if (y_ff != ye_ff) begin
         adv_x     = xs_ff;
         adv_y     = y_ff + CB'(1);
         adv_state = rfb_pkg::ST_MAP;
      end else if (entry_ff.kind == rfb_pkg::KIND_OUTLINE && span_ff != 2'd3) begin
         adv_span  = span_ff + 2'd1;
         adv_state = rfb_pkg::ST_SPAN;
      end else begin
         adv_state = rfb_pkg::ST_DONE;
      end
   end

   // rotation; MSB of the mapped values is the sign
   always_comb begin
      xw    = MB'(x_ff);
      yw    = MB'(y_ff);
      pw_m1 = MB'(cfg.panel_width) - MB'(1);
      ph_m1 = MB'(cfg.panel_height) - MB'(1);
      case (cfg.rotation)
         rfb_pkg::ROT_0: begin
            map_nx = xw;
            map_ny = yw;
         end
         rfb_pkg::ROT_90: begin
            map_nx = pw_m1 - yw;
            map_ny = xw;
         end
         rfb_pkg::ROT_180: begin
            map_nx = pw_m1 - xw;
            map_ny = ph_m1 - yw;
         end
         default: begin
            map_nx = yw;
            map_ny = ph_m1 - xw;
         end
      endcase
      if (cfg.mirror_enable) begin
         map_nx = map_nx + MB'(cfg.pad_offset);
      end
   end

   always_comb begin
      pos_calc = PB'(ny_ff[MB-2:0]) * PB'(cfg.line_stride) + PB'(nx_ff[MB-2:3]);
      addr_ok  = !nx_ff[MB-1] && !ny_ff[MB-1] && (32'(pos_calc) < PLANE_LIMIT);
      read_ok  = 32'(entry_ff.addr) < PLANE_LIMIT;
      // any color but white clears the bw bit (the unused fourth code too)
      bw_new   = (entry_ff.color != rfb_pkg::COLOR_WHITE) ? (bw_rd_ff & ~mask_ff) : bw_rd_ff;
      red_new  = (cfg.red_enable && entry_ff.color == rfb_pkg::COLOR_RED) ?
                 (red_rd_ff | mask_ff) : red_rd_ff;
   end

   always_comb begin
      state_in     = state_ff;
      entry_in     = entry_ff;
      clr_addr_in  = clr_addr_ff;
      span_in      = span_ff;
      xs_in        = xs_ff;
      xe_in        = xe_ff;
      ye_in        = ye_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      nx_in        = nx_ff;
      ny_in        = ny_ff;
      pos_in       = pos_ff;
      mask_in      = mask_ff;
      drop_in      = drop_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = pos_ff;
      bw_wdata     = bw_new;
      red_wdata    = red_new;
      rd_en        = 1'b0;
      rd_addr      = pos_ff;

      case (state_ff)
         rfb_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_ff;
            bw_wdata  = rfb_pkg::BW_BLANK;
            red_wdata = rfb_pkg::RED_BLANK;
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = rfb_pkg::ST_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + AW'(1);
            end
         end
         rfb_pkg::ST_IDLE: begin
            if (q_head.valid) begin
               q_pop    = 1'b1;
               entry_in = q_head.entry;
               span_in  = 2'd0;
               drop_in  = 1'b0;
               case (q_head.entry.kind)
                  rfb_pkg::KIND_FILL,
                  rfb_pkg::KIND_OUTLINE: state_in = rfb_pkg::ST_SPAN;
                  rfb_pkg::KIND_READ:    state_in = rfb_pkg::ST_RDBYTE;
                  default:               state_in = rfb_pkg::ST_DONE;
               endcase
            end
         end
         rfb_pkg::ST_SPAN: begin
            xs_in    = span_xs;
            xe_in    = span_xe;
            ye_in    = span_ye;
            x_in     = span_xs;
            y_in     = span_ys;
            state_in = rfb_pkg::ST_MAP;
         end
         rfb_pkg::ST_MAP: begin
            nx_in    = map_nx;
            ny_in    = map_ny;
            state_in = rfb_pkg::ST_ADDR;
         end
         rfb_pkg::ST_ADDR: begin
            pos_in  = AW'(pos_calc);
            mask_in = rfb_pkg::MASK_MSB >> nx_ff[2:0];
            if (addr_ok) begin
               state_in = rfb_pkg::ST_READ;
            end else begin
               drop_in  = 1'b1;
               x_in     = adv_x;
               y_in     = adv_y;
               span_in  = adv_span;
               state_in = adv_state;
            end
         end
         rfb_pkg::ST_READ: begin
            rd_en    = 1'b1;
            state_in = rfb_pkg::ST_WRITE;
         end
         rfb_pkg::ST_WRITE: begin
            mem_we   = 1'b1;
            x_in     = adv_x;
            y_in     = adv_y;
            span_in  = adv_span;
            state_in = adv_state;
         end
         rfb_pkg::ST_RDBYTE: begin
            rd_addr = AW'(entry_ff.addr);
            if (read_ok) begin
               rd_en = 1'b1;
            end else begin
               drop_in = 1'b1;
            end
            state_in = rfb_pkg::ST_DONE;
         end
         rfb_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               if (entry_ff.kind == rfb_pkg::KIND_READ && !drop_ff) begin
                  rsp_in.bw_byte  = bw_rd_ff;
                  rsp_in.red_byte = red_rd_ff;
               end else begin
                  rsp_in.bw_byte  = '0;
                  rsp_in.red_byte = '0;
               end
               rsp_in.dropped = drop_ff;
               state_in       = rfb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rfb_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rfb_pkg::ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      span_ff  <= span_in;
      xs_ff    <= xs_in;
      xe_ff    <= xe_in;
      ye_ff    <= ye_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      nx_ff    <= nx_in;
      ny_ff    <= ny_in;
      pos_ff   <= pos_in;
      mask_ff  <= mask_in;
      drop_ff  <= drop_in;
      rsp_ff   <= rsp_in;
   end

   // framebuffer planes: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         bw_mem[mem_waddr]  <= bw_wdata;
         red_mem[mem_waddr] <= red_wdata;
      end
      if (rd_en) begin
         bw_rd_ff  <= bw_mem[rd_addr];
         red_rd_ff <= red_mem[rd_addr];
      end
   end

   assign clearing    = (state_ff == rfb_pkg::ST_CLEAR);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

>>> tb/rotated_framebuffer_draw_engine_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rotated_framebuffer_draw_engine_test
// Self-checking bench for the draw engine. A scoreboard class tracks its own
// copy of both planes and the registers, predicts each response and checks
// it. Drawing runs through several rotation / mirror / panel settings, with
// random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module rotated_framebuffer_draw_engine_test;
   import rfb_pkg::*;

   localparam int PLANE_BYTES  = rfb_pkg::PLANE_BYTES_DEF;
   localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
   localparam int ADDR_MAX     = (1 << ADDR_BITS) - 1;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 85;
   localparam int REPORT_LIMIT = 10;

   // func and color codes with no name in the package
   localparam logic [2:0] FUNC_SPARE_LO = 3'd6;
   localparam logic [2:0] FUNC_SPARE_HI = 3'd7;
   localparam logic [1:0] COLOR_SPARE   = 2'd3;

   typedef enum {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_TOGGLE} flow_kind;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   req_type                   req_payload;
   logic                      rsp_valid;
   logic                      rsp_stall;
   rsp_type                   rsp_payload;
   logic                      csr_write_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   rotated_framebuffer_draw_engine dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_payload  (req_payload),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // Tracks both planes and the registers; predicts one response per command.
   class plane_tracker;
      logic [7:0] bw_mem  [PLANE_BYTES];
      logic [7:0] red_mem [PLANE_BYTES];
      cfg_type    regs;
      rsp_type    awaited[$];
      int         recent_pos;
      int         mismatches;
      int         commands_taken;
      int         results_seen;
      int         drops_seen;
      int         reads_taken;

      function void restart();
         foreach (bw_mem[i]) begin
            bw_mem[i]  = BW_BLANK;
            red_mem[i] = RED_BLANK;
         end
         regs              = '0;
         regs.panel_width  = PANEL_WIDTH_RST;
         regs.panel_height = PANEL_HEIGHT_RST;
         regs.line_stride  = LINE_STRIDE_RST;
         recent_pos        = 0;
      endfunction

      function void set_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
         case (idx)
            CSR_ROTATION:      regs.rotation      = data[1:0];
            CSR_MIRROR_ENABLE: regs.mirror_enable = data[0];
            CSR_PAD_OFFSET:    regs.pad_offset    = data[2:0];
            CSR_RED_ENABLE:    regs.red_enable    = data[0];
            CSR_PANEL_WIDTH:   regs.panel_width   = data[9:0];
            CSR_PANEL_HEIGHT:  regs.panel_height  = data[9:0];
            CSR_LINE_STRIDE:   regs.line_stride   = data[6:0];
            default: ;
         endcase
      endfunction

      // returns 1 when the pixel lands outside the store
      function bit plot_pixel(int x, int y, logic [1:0] color);
         int         nx;
         int         ny;
         int         pos;
         int         wd;
         int         ht;
         logic [7:0] mask;
         wd = int'(regs.panel_width);
         ht = int'(regs.panel_height);
         case (regs.rotation)
            ROT_0: begin
               nx = x;
               ny = y;
            end
            ROT_90: begin
               nx = wd - 1 - y;
               ny = x;
            end
            ROT_180: begin
               nx = wd - 1 - x;
               ny = ht - 1 - y;
            end
            default: begin
               nx = y;
               ny = ht - 1 - x;
            end
         endcase
         if (regs.mirror_enable)
            nx = nx + int'(regs.pad_offset);
         if (nx < 0 || ny < 0)
            return 1'b1;
         // column past the stride is not checked: it spills into the next row
         pos = ny * int'(regs.line_stride) + nx / 8;
         if (pos >= PLANE_BYTES)
            return 1'b1;
         mask = MASK_MSB >> (nx % 8);
         if (color != COLOR_WHITE)
            bw_mem[pos] &= ~mask;
         if (regs.red_enable && color == COLOR_RED)
            red_mem[pos] |= mask;
         recent_pos = pos;
         return 1'b0;
      endfunction

      function bit plot_row(int y, int xa, int xb, logic [1:0] color);
         bit hit;
         int lo;
         int hi;
         hit = 1'b0;
         lo  = (xa < xb) ? xa : xb;
         hi  = (xa < xb) ? xb : xa;
         for (int x = lo; x <= hi; x++)
            hit |= plot_pixel(x, y, color);
         return hit;
      endfunction

      function bit plot_column(int x, int ya, int yb, logic [1:0] color);
         bit hit;
         int lo;
         int hi;
         hit = 1'b0;
         lo  = (ya < yb) ? ya : yb;
         hi  = (ya < yb) ? yb : ya;
         for (int y = lo; y <= hi; y++)
            hit |= plot_pixel(x, y, color);
         return hit;
      endfunction

      function void take_command(req_type cmd);
         rsp_type want;
         int      x1;
         int      y1;
         int      x2;
         int      y2;
         want = '0;
         x1   = int'(cmd.x1);
         y1   = int'(cmd.y1);
         x2   = int'(cmd.x2);
         y2   = int'(cmd.y2);
         commands_taken++;
         case (cmd.func)
            FUNC_PIXEL: want.dropped = plot_pixel(x1, y1, cmd.color);
            FUNC_HLINE: want.dropped = plot_row(y1, x1, x2, cmd.color);
            FUNC_VLINE: want.dropped = plot_column(x1, y1, y2, cmd.color);
            FUNC_RECT: begin
               if (plot_row(y1, x1, x2, cmd.color))    want.dropped = 1'b1;
               if (plot_row(y2, x1, x2, cmd.color))    want.dropped = 1'b1;
               if (plot_column(x1, y1, y2, cmd.color)) want.dropped = 1'b1;
               if (plot_column(x2, y1, y2, cmd.color)) want.dropped = 1'b1;
            end
            FUNC_BOX: begin
               // y1 greater than y2 draws nothing
               for (int y = y1; y <= y2; y++)
                  if (plot_row(y, x1, x2, cmd.color))
                     want.dropped = 1'b1;
            end
            FUNC_READ: begin
               reads_taken++;
               if (int'(cmd.byte_address) < PLANE_BYTES) begin
                  want.bw_byte  = bw_mem[cmd.byte_address];
                  want.red_byte = red_mem[cmd.byte_address];
               end else begin
                  want.dropped = 1'b1;
               end
            end
            default: ;
         endcase
         awaited.push_back(want);
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         results_seen++;
         if (got.dropped)
            drops_seen++;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: response with no command outstanding: bw %h red %h dropped %b",
                        $time, got.bw_byte, got.red_byte, got.dropped);
            return;
         end
         want = awaited.pop_front();
         if (got.bw_byte !== want.bw_byte || got.red_byte !== want.red_byte ||
             got.dropped !== want.dropped) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: response %0d: expected bw %h red %h dropped %b, got bw %h red %h dropped %b",
                        $time, results_seen, want.bw_byte, want.red_byte, want.dropped,
                        got.bw_byte, got.red_byte, got.dropped);
         end
      endfunction

      function int pending();
         return awaited.size();
      endfunction
   endclass

   plane_tracker board;
   int           burst_left;
   bit           sender_gaps;
   bit           hold_request;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #80_000_000;
      $display("Mismatches found");
      $finish;
   end

   // receiver: stall pattern of its own, plus long hold-offs
   initial begin : receiver
      flow_kind mode;
      int       window;
      int       hold;
      rsp_stall <= 1'b0;
      mode   = FLOW_FREE;
      window = 0;
      hold   = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold = 600;
         end else if (hold == 0 && $urandom_range(0, 2999) == 0) begin
            hold = $urandom_range(100, 300);
         end
         if (window == 0) begin
            mode   = flow_kind'($urandom_range(0, 3));
            window = $urandom_range(20, 200);
         end
         window--;
         if (hold > 0) begin
            hold--;
            rsp_stall <= 1'b1;
         end else begin
            case (mode)
               FLOW_FREE:  rsp_stall <= 1'b0;
               FLOW_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               FLOW_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
               default:    rsp_stall <= ~rsp_stall;
            endcase
         end
      end
   end

   initial begin : result_monitor
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            board.check_result(rsp_payload);
      end
   end

   // one command beat; the sender can idle between bursts of random length
   task automatic offer(input req_type cmd);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = sender_gaps ? $urandom_range(0, 12) : 0;
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid   <= 1'b1;
      req_payload <= cmd;
      do @(posedge clock); while (req_stall);
      board.take_command(cmd);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (board.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      board.set_reg(idx, data);
   endtask

   task automatic configure(input cfg_type c);
      write_reg(CSR_ROTATION,      CSR_DATA_BITS'(c.rotation));
      write_reg(CSR_MIRROR_ENABLE, CSR_DATA_BITS'(c.mirror_enable));
      write_reg(CSR_PAD_OFFSET,    CSR_DATA_BITS'(c.pad_offset));
      write_reg(CSR_RED_ENABLE,    CSR_DATA_BITS'(c.red_enable));
      write_reg(CSR_PANEL_WIDTH,   CSR_DATA_BITS'(c.panel_width));
      write_reg(CSR_PANEL_HEIGHT,  CSR_DATA_BITS'(c.panel_height));
      write_reg(CSR_LINE_STRIDE,   CSR_DATA_BITS'(c.line_stride));
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   function automatic req_type make_cmd(logic [2:0] func, int x1, int y1, int x2, int y2,
                                        logic [1:0] color, int addr);
      req_type cmd;
      cmd.func         = func;
      cmd.x1           = COORD_BITS'(x1);
      cmd.y1           = COORD_BITS'(y1);
      cmd.x2           = COORD_BITS'(x2);
      cmd.y2           = COORD_BITS'(y2);
      cmd.color        = color;
      cmd.byte_address = ADDR_BITS'(addr);
      return cmd;
   endfunction

   function automatic int clamp(int v, int hi);
      if (v < 0)
         return 0;
      if (v > hi)
         return hi;
      return v;
   endfunction

   function automatic int near(int base, int reach);
      return clamp(base + int'($urandom_range(0, 2 * reach)) - reach, COORD_MAX);
   endfunction

   // mostly the upper-left corner so that pixels land in the store
   function automatic int coord();
      if ($urandom_range(0, 9) < 6)
         return $urandom_range(0, 63);
      return $urandom_range(0, COORD_MAX);
   endfunction

   function automatic req_type random_command();
      req_type    cmd;
      logic [2:0] func;
      logic [1:0] color;
      int         pick;
      int         x1;
      int         y1;
      int         x2;
      int         y2;
      int         addr;
      bit         wide;
      pick = $urandom_range(0, 99);
      if (pick < 14)      func = FUNC_PIXEL;
      else if (pick < 28) func = FUNC_HLINE;
      else if (pick < 42) func = FUNC_VLINE;
      else if (pick < 54) func = FUNC_RECT;
      else if (pick < 70) func = FUNC_BOX;
      else if (pick < 96) func = FUNC_READ;
      else if (pick < 98) func = FUNC_SPARE_LO;
      else                func = FUNC_SPARE_HI;
      pick = $urandom_range(0, 9);
      if (pick < 3)      color = COLOR_BLACK;
      else if (pick < 5) color = COLOR_WHITE;
      else if (pick < 9) color = COLOR_RED;
      else               color = COLOR_SPARE;
      // a few long spans; most stay short to keep the run fast
      wide = ($urandom_range(0, 24) == 0);
      x1 = coord();
      y1 = coord();
      x2 = wide ? int'($urandom_range(0, COORD_MAX)) : near(x1, 15);
      if (func == FUNC_BOX) begin
         if ($urandom_range(0, 5) == 0)
            y2 = near(y1, 7);
         else
            y2 = clamp(y1 + int'($urandom_range(0, wide ? 3 : 7)), COORD_MAX);
      end else begin
         y2 = wide ? int'($urandom_range(0, COORD_MAX)) : near(y1, 15);
      end
      pick = $urandom_range(0, 99);
      if (pick < 50)
         addr = clamp(board.recent_pos + int'($urandom_range(0, 6)) - 3, PLANE_BYTES - 1);
      else if (pick < 88)
         addr = $urandom_range(0, PLANE_BYTES - 1);
      else
         addr = $urandom_range(0, ADDR_MAX);
      cmd = make_cmd(func, x1, y1, x2, y2, color, addr);
      return cmd;
   endfunction

   function automatic cfg_type phase_setup(int phase);
      cfg_type c;
      c.rotation      = ROT_0;
      c.mirror_enable = 1'b0;
      c.pad_offset    = 3'd0;
      c.red_enable    = 1'b1;
      c.panel_width   = PANEL_WIDTH_RST;
      c.panel_height  = PANEL_HEIGHT_RST;
      c.line_stride   = LINE_STRIDE_RST;
      case (phase)
         0: begin
            c.rotation      = ROT_270;
            c.mirror_enable = 1'b1;
            c.pad_offset    = 3'd7;
            c.panel_width   = 10'd512;
            c.panel_height  = 10'd512;
            c.line_stride   = 7'd64;
         end
         1: begin
            c.rotation      = ROT_90;
            c.mirror_enable = 1'b1;
            c.panel_width   = 10'd1;
            c.panel_height  = 10'd1;
            c.line_stride   = 7'd1;
         end
         2: c.rotation = ROT_180;
         3: begin
            c.mirror_enable = 1'b1;
            c.pad_offset    = 3'($urandom_range(1, 7));
         end
         default: begin
            c.rotation      = 2'($urandom_range(0, 3));
            c.mirror_enable = 1'($urandom_range(0, 1));
            c.pad_offset    = 3'($urandom_range(0, 7));
            c.red_enable    = ($urandom_range(0, 3) != 0);
            c.panel_width   = 10'($urandom_range(0, 4) == 0 ? $urandom_range(1, 512)
                                                          : $urandom_range(64, 512));
            c.panel_height  = 10'($urandom_range(0, 4) == 0 ? $urandom_range(1, 512)
                                                          : $urandom_range(64, 512));
            c.line_stride   = 7'($urandom_range(1, 64));
         end
      endcase
      return c;
   endfunction

   initial begin : stimulus
      int phase;
      board = new;
      board.restart();
      burst_left   = 0;
      sender_gaps  = 1'b1;
      hold_request = 1'b0;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_payload  <= '0;
      csr_write_en <= 1'b0;
      csr_index    <= '0;
      csr_wdata    <= '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // clearing pass holds the input stalled
      repeat (4) @(posedge clock);
      while (req_stall) @(posedge clock);

      // reset settings: reads of blank planes, each command kind, edge cases
      offer(make_cmd(FUNC_READ,  0, 0, 0, 0, COLOR_BLACK, 0));
      offer(make_cmd(FUNC_READ,  0, 0, 0, 0, COLOR_BLACK, PLANE_BYTES - 1));
      offer(make_cmd(FUNC_READ,  0, 0, 0, 0, COLOR_BLACK, PLANE_BYTES));
      offer(make_cmd(FUNC_READ,  0, 0, 0, 0, COLOR_BLACK, ADDR_MAX));
      offer(make_cmd(FUNC_PIXEL, 0, 0, 0, 0, COLOR_BLACK, 0));
      offer(make_cmd(FUNC_PIXEL, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COLOR_BLACK, 0));
      offer(make_cmd(FUNC_HLINE, 20, 1, 3, 0, COLOR_RED, 0));
      offer(make_cmd(FUNC_VLINE, 5, 10, 9, 2, COLOR_BLACK, 0));
      offer(make_cmd(FUNC_RECT,  8, 20, 30, 40, COLOR_SPARE, 0));
      offer(make_cmd(FUNC_BOX,   40, 50, 33, 55, COLOR_RED, 0));
      offer(make_cmd(FUNC_BOX,   0, 10, 5, 9, COLOR_BLACK, 0));
      offer(make_cmd(FUNC_HLINE, 0, 1, 15, 0, COLOR_WHITE, 0));
      offer(make_cmd(FUNC_SPARE_LO, 3, 3, 4, 4, COLOR_BLACK, 0));
      offer(make_cmd(FUNC_SPARE_HI, COORD_MAX, 0, 0, COORD_MAX, COLOR_RED, ADDR_MAX));
      offer(make_cmd(FUNC_RECT,  0, 0, COORD_MAX, COORD_MAX, COLOR_BLACK, 0));
      offer(make_cmd(FUNC_BOX,   0, 100, COORD_MAX, 101, COLOR_BLACK, 0));
      offer(make_cmd(FUNC_READ,  0, 0, 0, 0, COLOR_BLACK, 0));
      offer(make_cmd(FUNC_READ,  0, 0, 0, 0, COLOR_BLACK, 16));
      offer(make_cmd(FUNC_READ,  0, 0, 0, 0, COLOR_BLACK, 17));
      offer(make_cmd(FUNC_READ,  0, 0, 0, 0, COLOR_BLACK, 32));
      offer(make_cmd(FUNC_READ,  0, 0, 0, 0, COLOR_BLACK, 20 * 16 + 1));
      offer(make_cmd(FUNC_READ,  0, 0, 0, 0, COLOR_BLACK, 50 * 16 + 4));
      offer(make_cmd(FUNC_READ,  0, 0, 0, 0, COLOR_BLACK, 100 * 16 + 63));
      offer(make_cmd(FUNC_READ,  0, 0, 0, 0, COLOR_BLACK, 2 * 16 + 1));
      drain_results();

      for (phase = 0; phase < PHASES; phase++) begin
         configure(phase_setup(phase));
         sender_gaps = (phase % 3 != 2);
         // receiver holds off while commands keep coming, filling the queue
         if (phase == 0)
            hold_request = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == 3 && n == PHASE_ITEMS / 2)
               drain_results();
            offer(random_command());
         end
         drain_results();
      end

      repeat (12) @(posedge clock);
      $display("Covered %0d commands (%0d reads) across %0d register settings.",
               board.commands_taken, board.reads_taken, PHASES + 1);
      $display("Checked %0d responses, %0d of them flagged as dropped.",
               board.results_seen, board.drops_seen);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

>>> rotated_framebuffer_draw_engine.f
rtl/core/rfb_pkg.sv
rtl/core/rfb_front.sv
rtl/core/rfb_back.sv
rtl/core/rotated_framebuffer_draw_engine.sv
tb/rotated_framebuffer_draw_engine_test.sv
